[src/fat_cluster_link_table_assert.svh]
// Assertion macros for the cluster link table.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef FAT_CLUSTER_LINK_TABLE_ASSERT_SVH
`define FAT_CLUSTER_LINK_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define FCLT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fclt check failed");

// Next-cycle implication, checked outside reset
`define FCLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fclt check failed");

`endif

[src/fclt_pkg.sv]
package fclt_pkg;

  // Field and counter widths
  localparam int CNT_W = 9;
  localparam int IDX_W = 8;

  // Table geometry and fixed cluster numbers
  localparam int MAX_CLUSTERS_DEF = 256;
  localparam int TABLE_CLUSTER    = 1;
  localparam int ROOT_CLUSTER     = 2;
  localparam int FIRST_ALLOC      = 3;

  // Entry codes
  localparam logic [IDX_W-1:0] ENTRY_USED = 8'hFF;
  localparam logic [IDX_W-1:0] ENTRY_FREE = 8'h00;

  localparam logic [CNT_W-1:0] CLUSTERS_RST = 9'd256;

  // Request codes
  typedef enum logic [2:0] {
    FN_INIT      = 3'd0,
    FN_GET       = 3'd1,
    FN_SET       = 3'd2,
    FN_ALLOC     = 3'd3,
    FN_MARK_USED = 3'd4,
    FN_MARK_FREE = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    WA_ZERO, WA_TABLE, WA_ROOT, WA_CLUSTER, WA_CHK
  } wr_addr_sel_t;

  typedef enum logic [1:0] {
    WD_USED, WD_FREE, WD_LINK
  } wr_data_sel_t;

  typedef enum logic [1:0] {
    RA_ROOT, RA_CLUSTER, RA_PTR
  } rd_addr_sel_t;

  typedef enum logic [1:0] {
    RS_ZERO, RS_USED, RS_ENTRY, RS_CHK
  } res_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic         latch_in;
    logic         wr_en;
    wr_addr_sel_t wr_addr_sel;
    wr_data_sel_t wr_data_sel;
    rd_addr_sel_t rd_addr_sel;
    logic         scan_start;
    logic         scan_step;
    logic         res_load;
    res_sel_t     res_sel;
    logic         out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] func;
    logic       clu_in_range;
    logic       clu_special;
    logic       entry_free;
    logic       chk_valid;
    logic       chk_special;
    logic       scan_end;
    logic       out_free;
  } sts_t;

endpackage

[src/fclt_ctrl.sv]
module fclt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2:0]        in_func,
  output logic              in_ready,
  output fclt_pkg::cmd_t    cmd,
  input  fclt_pkg::sts_t    sts
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_INIT_A   = 9'b000000010,
    S_INIT_B   = 9'b000000100,
    S_INIT_C   = 9'b000001000,
    S_GET_RD   = 9'b000010000,
    S_GET_FIN  = 9'b000100000,
    S_WRITE    = 9'b001000000,
    S_SCAN     = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.rd_addr_sel = fclt_pkg::RA_CLUSTER;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          unique case (fclt_pkg::func_t'(in_func))
            fclt_pkg::FN_INIT:  state_next = S_INIT_A;
            fclt_pkg::FN_GET:   state_next = S_GET_RD;
            fclt_pkg::FN_SET,
            fclt_pkg::FN_MARK_USED,
            fclt_pkg::FN_MARK_FREE: state_next = S_WRITE;
            fclt_pkg::FN_ALLOC: begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
            default: begin
              // unused request codes: no table access, result zero
              cmd.res_load = 1'b1;
              cmd.res_sel  = fclt_pkg::RS_ZERO;
              state_next   = S_DONE;
            end
          endcase
        end
      end
      S_INIT_A: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = fclt_pkg::WA_ZERO;
        cmd.wr_data_sel = fclt_pkg::WD_USED;
        cmd.rd_addr_sel = fclt_pkg::RA_ROOT;
        state_next      = S_INIT_B;
      end
      S_INIT_B: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = fclt_pkg::WA_TABLE;
        cmd.wr_data_sel = fclt_pkg::WD_USED;
        cmd.rd_addr_sel = fclt_pkg::RA_ROOT;
        state_next      = S_INIT_C;
      end
      S_INIT_C: begin
        // root entry is claimed only when free
        cmd.wr_en       = sts.entry_free;
        cmd.wr_addr_sel = fclt_pkg::WA_ROOT;
        cmd.wr_data_sel = fclt_pkg::WD_USED;
        cmd.res_load    = 1'b1;
        cmd.res_sel     = fclt_pkg::RS_ZERO;
        state_next      = S_DONE;
      end
      S_GET_RD: begin
        state_next = S_GET_FIN;
      end
      S_GET_FIN: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = sts.clu_special ? fclt_pkg::RS_USED : fclt_pkg::RS_ENTRY;
        state_next   = S_DONE;
      end
      S_WRITE: begin
        cmd.wr_en       = sts.clu_in_range;
        cmd.wr_addr_sel = fclt_pkg::WA_CLUSTER;
        priority if (sts.func == fclt_pkg::FN_SET) begin
          cmd.wr_data_sel = fclt_pkg::WD_LINK;
        end else if (sts.func == fclt_pkg::FN_MARK_FREE) begin
          cmd.wr_data_sel = fclt_pkg::WD_FREE;
        end else begin
          cmd.wr_data_sel = fclt_pkg::WD_USED;
        end
        cmd.res_load = 1'b1;
        cmd.res_sel  = fclt_pkg::RS_ZERO;
        state_next   = S_DONE;
      end
      S_SCAN: begin
        // one read issued and one entry checked per cycle
        cmd.rd_addr_sel = fclt_pkg::RA_PTR;
        priority if (sts.chk_valid && sts.entry_free && !sts.chk_special) begin
          cmd.wr_en       = 1'b1;
          cmd.wr_addr_sel = fclt_pkg::WA_CHK;
          cmd.wr_data_sel = fclt_pkg::WD_USED;
          cmd.res_load    = 1'b1;
          cmd.res_sel     = fclt_pkg::RS_CHK;
          state_next      = S_DONE;
        end else if (sts.scan_end) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = fclt_pkg::RS_USED;
          state_next   = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/fclt_datapath.sv]
module fclt_datapath #(
  parameter int MAX_CLUSTERS = fclt_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [2*fclt_pkg::IDX_W-1:0] in_data,
  input  logic [2:0]                  in_func,
  input  logic                        cfg_valid,
  input  logic [fclt_pkg::CNT_W-1:0]  cfg_data,
  input  fclt_pkg::cmd_t              cmd,
  output fclt_pkg::sts_t              sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fclt_pkg::IDX_W-1:0]  out_data
);

  localparam int AW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam logic [fclt_pkg::CNT_W-1:0] MAX_CNT = fclt_pkg::CNT_W'(MAX_CLUSTERS);
  localparam logic [fclt_pkg::CNT_W-1:0] FIRST_CNT = fclt_pkg::CNT_W'(fclt_pkg::FIRST_ALLOC);

  logic [2:0]                 func_q;
  logic [fclt_pkg::IDX_W-1:0] cluster_q;
  logic [fclt_pkg::IDX_W-1:0] link_q;
  logic [fclt_pkg::CNT_W-1:0] clusters_in_use;
  logic [fclt_pkg::CNT_W-1:0] ptr;
  logic [fclt_pkg::IDX_W-1:0] chk_idx;
  logic                       chk_valid;
  logic [fclt_pkg::IDX_W-1:0] mem [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0]    ent_vld;
  logic [fclt_pkg::IDX_W-1:0] rd_data;
  logic                       rd_vld;
  logic [fclt_pkg::IDX_W-1:0] entry;
  logic [fclt_pkg::IDX_W-1:0] res_q;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic [fclt_pkg::IDX_W-1:0] wr_data;
  logic [fclt_pkg::IDX_W-1:0] res_val;
  logic                       clu_in_range;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      func_q    <= in_func;
      cluster_q <= in_data[fclt_pkg::IDX_W-1:0];
      link_q    <= in_data[2*fclt_pkg::IDX_W-1:fclt_pkg::IDX_W];
    end
  end

  // Cluster count register
  always_ff @(posedge clk) begin
    if (rst) begin
      clusters_in_use <= fclt_pkg::CLUSTERS_RST;
    end else if (cfg_valid) begin
      clusters_in_use <= cfg_data;
    end
  end

  // Allocation scan pointer and the index whose read is in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (cmd.scan_start) begin
      chk_valid <= 1'b0;
    end else if (cmd.scan_step) begin
      chk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      ptr <= FIRST_CNT;
    end else if (cmd.scan_step) begin
      ptr     <= ptr + fclt_pkg::CNT_W'(1);
      chk_idx <= ptr[fclt_pkg::IDX_W-1:0];
    end
  end

  // Port address and data selection
  always_comb begin
    unique case (cmd.wr_addr_sel)
      fclt_pkg::WA_ZERO:    wr_addr = '0;
      fclt_pkg::WA_TABLE:   wr_addr = AW'(fclt_pkg::TABLE_CLUSTER);
      fclt_pkg::WA_ROOT:    wr_addr = AW'(fclt_pkg::ROOT_CLUSTER);
      fclt_pkg::WA_CLUSTER: wr_addr = cluster_q[AW-1:0];
      fclt_pkg::WA_CHK:     wr_addr = chk_idx[AW-1:0];
      default:              wr_addr = '0;
    endcase
    unique case (cmd.wr_data_sel)
      fclt_pkg::WD_USED: wr_data = fclt_pkg::ENTRY_USED;
      fclt_pkg::WD_FREE: wr_data = fclt_pkg::ENTRY_FREE;
      fclt_pkg::WD_LINK: wr_data = link_q;
      default:           wr_data = fclt_pkg::ENTRY_FREE;
    endcase
    unique case (cmd.rd_addr_sel)
      fclt_pkg::RA_ROOT:    rd_addr = AW'(fclt_pkg::ROOT_CLUSTER);
      fclt_pkg::RA_CLUSTER: rd_addr = cluster_q[AW-1:0];
      fclt_pkg::RA_PTR:     rd_addr = ptr[AW-1:0];
      default:              rd_addr = '0;
    endcase
  end

  // Link table storage, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Per-entry written flags; an unwritten entry reads as free
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        ent_vld[wr_addr] <= 1'b1;
      end
      rd_vld <= ent_vld[rd_addr];
    end
  end

  assign entry = rd_vld ? rd_data : fclt_pkg::ENTRY_FREE;

  // Result selection and hold
  always_comb begin
    unique case (cmd.res_sel)
      fclt_pkg::RS_ZERO:  res_val = '0;
      fclt_pkg::RS_USED:  res_val = fclt_pkg::ENTRY_USED;
      fclt_pkg::RS_ENTRY: res_val = entry;
      fclt_pkg::RS_CHK:   res_val = chk_idx;
      default:            res_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_q <= res_val;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= res_q;
    end
  end

  // Status back to the controller
  assign clu_in_range = ({1'b0, cluster_q} < MAX_CNT);

  always_comb begin
    sts              = '0;
    sts.func         = func_q;
    sts.clu_in_range = clu_in_range;
    sts.clu_special  = (cluster_q == '0) || (cluster_q == fclt_pkg::ENTRY_USED) ||
                       !clu_in_range;
    sts.entry_free   = (entry == fclt_pkg::ENTRY_FREE);
    sts.chk_valid    = chk_valid;
    sts.chk_special  = (chk_idx == '0) || (chk_idx == fclt_pkg::ENTRY_USED);
    sts.scan_end     = (ptr >= clusters_in_use) || (ptr >= MAX_CNT);
    sts.out_free     = !out_valid || out_ready;
  end

endmodule

[src/fat_cluster_link_table.sv]
// Cluster link table: a store of 8-bit link entries (0 free, 0xFF used or end).
// Requests come in on the s_axis channel, one at a time; each gives exactly one
// result transaction on m_axis, in order. cfg carries the cluster count that
// bounds the allocation scan; write it only while no request is in progress.
// Allocation checks entries from cluster 3 up to and including the first free
// one, at most min(count, MAX_CLUSTERS) - 3 and none for a count of 3 or less;
// the scan reads one entry per cycle through the single read port.
// A new request is taken only when the controller is idle, which can be while
// the previous result still waits in the output register.
// Reset: the table reads as all free (per-entry written flags are cleared at
// once, no clearing pass), the count returns to 256 and no result is pending.
// If m_axis_tready stays low, the result holds and at most one more request is
// taken and finished internally before the block stops accepting.
module fat_cluster_link_table #(
  parameter int MAX_CLUSTERS = fclt_pkg::MAX_CLUSTERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // cluster [7:0], link_value [15:8]
  input  logic [2:0]  s_axis_tuser,   // func [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // result_value [7:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);

  fclt_pkg::cmd_t cmd;
  fclt_pkg::sts_t sts;

  // Config writes always land
  assign cfg_ready = 1'b1;

  fclt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_func  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  fclt_datapath #(
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .in_func   (s_axis_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

[src/fclt_checker.sv]
`include "fat_cluster_link_table_assert.svh"

module fclt_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  logic [1:0] pend;
  logic       s_xfer;
  logic       m_xfer;

  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign m_xfer = m_axis_tvalid && m_axis_tready;

  // Requests accepted whose result is not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (s_xfer && !m_xfer) begin
      pend <= pend + 2'd1;
    end else if (m_xfer && !s_xfer) begin
      pend <= pend - 2'd1;
    end
  end

  // A result is only shown for an accepted request
  `FCLT_ASSERT_NOW(a_no_orphan_result, m_axis_tvalid, pend != 2'd0)
  // At most one request in work plus one result waiting
  `FCLT_ASSERT_NOW(a_pend_bound, s_xfer, pend != 2'd2)
  // One request at a time: not ready right after a transaction
  `FCLT_ASSERT_NEXT(a_one_at_a_time, s_xfer, !s_axis_tready)
  // A stalled result holds
  `FCLT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind fat_cluster_link_table fclt_checker u_fclt_checker (.*);

[dv/tb_fat_cluster_link_table.sv]
module tb_fat_cluster_link_table;
  timeunit 1ns;
  timeprecision 1ps;

  import fclt_pkg::*;

  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 20;

  // Directed rows: either a request or a cluster count write
  typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [2:0] fn;
    logic [7:0] cl;
    logic [7:0] lv;
    bit         has_res;
    logic [7:0] res;
    logic [8:0] count;
  } link_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;    // cluster [7:0], link_value [15:8]
  logic [2:0]  s_axis_tuser = '0;    // func [2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [7:0]  m_axis_tdata;         // result_value [7:0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;

  // Fixed expectation of the request on the bus, if the row gives one
  bit          cur_has_res = 1'b0;
  logic [7:0]  cur_res = '0;

  // Shadow table and cluster count
  logic [7:0]  link_mem [MAX_CLUSTERS_DEF];
  logic [8:0]  shadow_count;
  logic [7:0]  expected_links [$];

  int          reqs_sent = 0;
  int          results_checked = 0;
  int          n_fail = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  bit          hold_rx = 1'b0;

  fat_cluster_link_table i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Entry read as the block sees it: clusters 0 and 0xFF always read used
  function automatic logic [7:0] read_link(int idx);
    if (idx == 0 || idx == 8'hFF || idx >= MAX_CLUSTERS_DEF) return ENTRY_USED;
    return link_mem[idx];
  endfunction

  // Applies one request to the shadow table and returns its result
  function automatic logic [7:0] predict_link_result(logic [2:0] fn, logic [7:0] cl,
                                                     logic [7:0] lv);
    logic [7:0] res;
    int         lim;
    res = ENTRY_FREE;
    case (fn)
      FN_INIT: begin
        link_mem[0] = ENTRY_USED;
        link_mem[TABLE_CLUSTER] = ENTRY_USED;
        if (read_link(ROOT_CLUSTER) == ENTRY_FREE) link_mem[ROOT_CLUSTER] = ENTRY_USED;
      end
      FN_GET:       res = read_link(cl);
      FN_SET:       link_mem[cl] = lv;
      FN_ALLOC: begin
        lim = (shadow_count > MAX_CLUSTERS_DEF) ? MAX_CLUSTERS_DEF : shadow_count;
        res = ENTRY_USED;
        for (int i = FIRST_ALLOC; i < lim; i++) begin
          if (read_link(i) == ENTRY_FREE) begin
            link_mem[i] = ENTRY_USED;
            res = i[7:0];
            break;
          end
        end
      end
      FN_MARK_USED: link_mem[cl] = ENTRY_USED;
      FN_MARK_FREE: link_mem[cl] = ENTRY_FREE;
      default: ;
    endcase
    return res;
  endfunction

  // Bus monitor: predicts on request transactions, checks result transactions
  always @(posedge clk) begin
    if (rst) begin
      foreach (link_mem[i]) link_mem[i] = ENTRY_FREE;
      shadow_count = CLUSTERS_RST;
    end else begin
      if (cfg_valid && cfg_ready) shadow_count = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        logic [7:0] pred;
        pred = predict_link_result(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
        expected_links.push_back(cur_has_res ? cur_res : pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_links.size() == 0) begin
          $error("result_value: no result expected, got %02h", m_axis_tdata);
          n_fail++;
        end else begin
          logic [7:0] exp_res;
          exp_res = expected_links.pop_front();
          if (m_axis_tdata !== exp_res) begin
            $error("result_value: expected %02h, got %02h", exp_res, m_axis_tdata);
            n_fail++;
          end
        end
        results_checked++;
      end
    end
  end

  // Result side ready: random stalls, plus one long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic link_req_t req_row(logic [2:0] fn, logic [7:0] cl, logic [7:0] lv);
    link_req_t r;
    r = '0;
    r.kind = ROW_REQ;
    r.fn = fn;
    r.cl = cl;
    r.lv = lv;
    return r;
  endfunction

  function automatic link_req_t chk_row(logic [2:0] fn, logic [7:0] cl, logic [7:0] lv,
                                        logic [7:0] res);
    link_req_t r;
    r = req_row(fn, cl, lv);
    r.has_res = 1'b1;
    r.res = res;
    return r;
  endfunction

  function automatic link_req_t cfg_row(logic [8:0] count);
    link_req_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.count = count;
    return r;
  endfunction

  // Random request, mostly aimed at clusters the allocator can reach
  function automatic link_req_t rand_req();
    link_req_t r;
    int        sel;
    int        lim;
    r = '0;
    r.kind = ROW_REQ;
    lim = (shadow_count > MAX_CLUSTERS_DEF) ? MAX_CLUSTERS_DEF : shadow_count;
    sel = $urandom_range(99);
    if (sel < 28)      r.fn = FN_ALLOC;
    else if (sel < 46) r.fn = FN_MARK_FREE;
    else if (sel < 64) r.fn = FN_GET;
    else if (sel < 76) r.fn = FN_SET;
    else if (sel < 84) r.fn = FN_MARK_USED;
    else if (sel < 90) r.fn = FN_INIT;
    else if (sel < 94) r.fn = 3'd6 + 3'($urandom_range(1));
    else               r.fn = FN_GET;
    if (lim > 0 && $urandom_range(3) != 0) r.cl = 8'($urandom_range(lim - 1));
    else                                   r.cl = 8'($urandom);
    r.lv = ($urandom_range(3) == 0) ? ENTRY_FREE : 8'($urandom);
    return r;
  endfunction

  // Offers one request, with random idle cycles ahead of it
  task automatic send_item(link_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.fn;
    s_axis_tdata  <= {r.lv, r.cl};
    cur_has_res   <= r.has_res;
    cur_res       <= r.res;
    do @(posedge clk); while (!s_axis_tready);
    reqs_sent++;
  endtask

  // Waits until every accepted request has produced its result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (results_checked != reqs_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cluster_count(logic [8:0] count);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [8:0] count, int tx_pct, int rx_pct, bit hold, int n);
    write_cluster_count(count);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    hold_rx      = hold;
    repeat (n) send_item(rand_req());
    drain_results();
  endtask

  initial begin
    link_req_t dir_rows [$];

    // Directed part: reset state, init, special indices, allocation limits
    dir_rows.push_back(chk_row(FN_GET, 8'h05, 8'h00, ENTRY_FREE));
    dir_rows.push_back(chk_row(FN_GET, 8'h00, 8'h00, ENTRY_USED));
    dir_rows.push_back(chk_row(FN_GET, 8'hFF, 8'h00, ENTRY_USED));
    dir_rows.push_back(chk_row(FN_INIT, 8'h00, 8'h00, ENTRY_FREE));
    dir_rows.push_back(chk_row(FN_GET, 8'h01, 8'h00, ENTRY_USED));
    dir_rows.push_back(chk_row(FN_GET, 8'h02, 8'h00, ENTRY_USED));
    dir_rows.push_back(chk_row(FN_ALLOC, 8'h00, 8'h00, 8'h03));
    dir_rows.push_back(chk_row(FN_SET, 8'h03, 8'hAA, ENTRY_FREE));
    dir_rows.push_back(req_row(FN_GET, 8'h03, 8'h00));
    dir_rows.push_back(req_row(FN_SET, 8'hFE, 8'h55));
    dir_rows.push_back(req_row(FN_GET, 8'hFE, 8'h00));
    dir_rows.push_back(req_row(FN_MARK_USED, 8'h04, 8'h00));
    dir_rows.push_back(req_row(FN_ALLOC, 8'h00, 8'h00));
    // root entry is refilled by init only while it is free
    dir_rows.push_back(req_row(FN_MARK_FREE, 8'h02, 8'h00));
    dir_rows.push_back(req_row(FN_INIT, 8'h00, 8'h00));
    dir_rows.push_back(req_row(FN_GET, 8'h02, 8'h00));
    dir_rows.push_back(req_row(FN_SET, 8'h02, 8'h07));
    dir_rows.push_back(req_row(FN_INIT, 8'h00, 8'h00));
    dir_rows.push_back(req_row(FN_GET, 8'h02, 8'h00));
    // unused codes do nothing
    dir_rows.push_back(chk_row(3'd6, 8'hFF, 8'hFF, ENTRY_FREE));
    dir_rows.push_back(chk_row(3'd7, 8'h00, 8'h00, ENTRY_FREE));
    // entries 0 and 0xFF read used whatever was written
    dir_rows.push_back(chk_row(FN_SET, 8'hFF, 8'h12, ENTRY_FREE));
    dir_rows.push_back(chk_row(FN_GET, 8'hFF, 8'h00, ENTRY_USED));
    dir_rows.push_back(req_row(FN_MARK_FREE, 8'h00, 8'h00));
    dir_rows.push_back(chk_row(FN_GET, 8'h00, 8'h00, ENTRY_USED));
    // nothing free below the count, then a count above the table size
    dir_rows.push_back(cfg_row(9'd4));
    dir_rows.push_back(chk_row(FN_ALLOC, 8'h00, 8'h00, ENTRY_USED));
    dir_rows.push_back(cfg_row(9'd0));
    dir_rows.push_back(chk_row(FN_ALLOC, 8'h00, 8'h00, ENTRY_USED));
    dir_rows.push_back(cfg_row(9'd511));
    dir_rows.push_back(req_row(FN_ALLOC, 8'h00, 8'h00));

    while (rst) @(posedge clk);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_cluster_count(dir_rows[i].count);
      else send_item(dir_rows[i]);
    end
    drain_results();

    // Random part across counts and idle patterns
    run_phase(9'd256, 0, 0, 1'b0, 90);
    run_phase(9'd16, 88, 0, 1'b0, 90);
    run_phase(9'd8, 0, 88, 1'b0, 90);
    run_phase(9'd511, 9, 9, 1'b0, 90);
    run_phase(9'd3, 0, 0, 1'b1, 60);
    run_phase(9'd100, 9, 9, 1'b0, 100);
    run_phase(9'd0, 0, 88, 1'b0, 60);
    run_phase(9'd255, 88, 0, 1'b0, 80);
    run_phase(9'd300, 0, 0, 1'b1, 80);
    run_phase(9'd4, 0, 0, 1'b0, 60);

    if (expected_links.size() != 0) begin
      $error("result_value: %0d results never arrived", expected_links.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("fat_cluster_link_table test passed");
    end else begin
      $display("fat_cluster_link_table test failed");
    end
    $finish;
  end

  // Reset: held at the start only
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // Timeout
  initial begin
    #10_000_000;
    $display("fat_cluster_link_table test failed");
    $finish;
  end

endmodule
